[rtl/core/arfo_pkg.sv]
package arfo_pkg;

   // Frame store geometry
   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int XBITS       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YBITS       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int EWBITS      = $clog2(MAX_WIDTH + 1);
   localparam int EHBITS      = $clog2(MAX_HEIGHT + 1);

   // Item field widths
   localparam int ACT_BITS   = 2;
   localparam int COORD_BITS = 12;
   localparam int EXT_BITS   = COORD_BITS + 1;
   localparam int PAINT_BITS = 32;
   localparam int PIX_BITS   = 24;
   localparam int CNT_BITS   = 13;
   localparam int CSR_BITS   = 7;
   localparam int CSR_IDX_BITS = 1;

   localparam logic [CSR_BITS-1:0] WIN_RESET = CSR_BITS'(64);

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_HEIGHT = 1'b1;

   // Action codes
   localparam logic [ACT_BITS-1:0] ACT_WRITE   = 2'd0;
   localparam logic [ACT_BITS-1:0] ACT_READ    = 2'd1;
   localparam logic [ACT_BITS-1:0] ACT_FILL    = 2'd2;
   localparam logic [ACT_BITS-1:0] ACT_OUTLINE = 2'd3;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic pix_wr;
      logic pix_cap;
      logic scan_step;
   } cmd_type;

   typedef struct packed {
      logic                clr_last;
      logic [ACT_BITS-1:0] action;
      logic                rect_empty;
      logic                scan_last;
      logic                pipe_busy;
   } status_type;

   // floor(p / 255) for any 16-bit product of two bytes
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] tmp;
      tmp = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
      return tmp[15:8];
   endfunction

endpackage

[rtl/core/arfo_ram.sv]
module arfo_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/core/arfo_ctrl.sv]
module arfo_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output arfo_pkg::cmd_type    cmd,
   input  arfo_pkg::status_type status
);
   import arfo_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SETUP  = 3'd2;
   localparam logic [2:0] ST_RDWAIT = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (status.clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = ST_SETUP;
         ST_SETUP: begin
            unique case (status.action)
               ACT_WRITE: state_in = ST_DONE;
               ACT_READ:  state_in = ST_RDWAIT;
               default:   state_in = status.rect_empty ? ST_DONE : ST_SCAN;
            endcase
         end
         ST_RDWAIT: state_in = ST_DONE;
         ST_SCAN:   if (status.scan_last) state_in = ST_DRAIN;
         ST_DRAIN:  if (!status.pipe_busy) state_in = ST_DONE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.clr_step  = (state_ff == ST_CLEAR);
      cmd.load      = (state_ff == ST_IDLE) && start;
      cmd.pix_wr    = (state_ff == ST_SETUP) && (status.action == ACT_WRITE);
      cmd.pix_cap   = (state_ff == ST_RDWAIT);
      cmd.scan_step = (state_ff == ST_SCAN);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

[rtl/core/arfo_dp.sv]
module arfo_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  arfo_pkg::cmd_type                     cmd,
   output arfo_pkg::status_type                  status,
   input  logic                                  csr_write_en,
   input  logic [arfo_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [arfo_pkg::CSR_BITS-1:0]         csr_wdata,
   input  logic [arfo_pkg::ACT_BITS-1:0]         req_action,
   input  logic [arfo_pkg::COORD_BITS-1:0]       req_pos_x,
   input  logic [arfo_pkg::COORD_BITS-1:0]       req_pos_y,
   input  logic [arfo_pkg::COORD_BITS-1:0]       req_rect_width,
   input  logic [arfo_pkg::COORD_BITS-1:0]       req_rect_height,
   input  logic [arfo_pkg::COORD_BITS-1:0]       req_border,
   input  logic [arfo_pkg::PAINT_BITS-1:0]       req_paint,
   output logic [arfo_pkg::PIX_BITS-1:0]         rsp_pixel,
   output logic [arfo_pkg::CNT_BITS-1:0]         rsp_pixels_written
);
   import arfo_pkg::*;

   // window registers
   logic [CSR_BITS-1:0] win_w_ff, win_h_ff;
   logic [EXT_BITS-1:0] eff_w, eff_h;

   // latched item
   logic [ACT_BITS-1:0]   action_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff, t_ff;
   logic [PAINT_BITS-1:0] paint_ff;
   logic [EXT_BITS-1:0]   xe_ff, ye_ff, xt_ff, yt_ff;
   logic [EWBITS-1:0]     xlim_ff;
   logic [EHBITS-1:0]     ylim_ff;

   // scan position
   logic [XBITS-1:0] px_ff, px_in;
   logic [YBITS-1:0] py_ff, py_in;

   // pipeline
   logic                 s1_valid_ff, s1_valid_in;
   logic [ADDR_BITS-1:0] s1_addr_ff;
   logic                 s2_valid_ff;
   logic [ADDR_BITS-1:0] s2_addr_ff;
   logic [15:0]          pd_ff [3];
   logic [15:0]          ps_ff [3];

   logic [ADDR_BITS-1:0] clr_cnt_ff;
   logic [CNT_BITS-1:0]  count_ff;
   logic [PIX_BITS-1:0]  pixel_ff;

   logic [EXT_BITS-1:0]  xe_c, ye_c, xlim_c, ylim_c;
   logic [EXT_BITS-1:0]  px_e, py_e, xlim_e, ylim_e;
   logic                 col_last, row_last, interior, in_window;
   logic [ADDR_BITS-1:0] scan_addr, pix_addr;
   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_waddr, ram_raddr;
   logic [PIX_BITS-1:0]  ram_wdata, ram_rdata, blended;

   assign eff_w = ({6'd0, win_w_ff} > EXT_BITS'(MAX_WIDTH))  ? EXT_BITS'(MAX_WIDTH)
                                                             : {6'd0, win_w_ff};
   assign eff_h = ({6'd0, win_h_ff} > EXT_BITS'(MAX_HEIGHT)) ? EXT_BITS'(MAX_HEIGHT)
                                                             : {6'd0, win_h_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         win_w_ff <= WIN_RESET;
         win_h_ff <= WIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WINDOW_WIDTH:  win_w_ff <= csr_wdata;
            CSR_WINDOW_HEIGHT: win_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clipped extent of the rectangle
   assign xe_c   = {1'b0, req_pos_x} + {1'b0, req_rect_width};
   assign ye_c   = {1'b0, req_pos_y} + {1'b0, req_rect_height};
   assign xlim_c = (xe_c < eff_w) ? xe_c : eff_w;
   assign ylim_c = (ye_c < eff_h) ? ye_c : eff_h;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         x_ff      <= req_pos_x;
         y_ff      <= req_pos_y;
         t_ff      <= req_border;
         paint_ff  <= req_paint;
         xe_ff     <= xe_c;
         ye_ff     <= ye_c;
         xt_ff     <= {1'b0, req_pos_x} + {1'b0, req_border};
         yt_ff     <= {1'b0, req_pos_y} + {1'b0, req_border};
         xlim_ff   <= EWBITS'(xlim_c);
         ylim_ff   <= EHBITS'(ylim_c);
      end
   end

   assign px_e   = EXT_BITS'(px_ff);
   assign py_e   = EXT_BITS'(py_ff);
   assign xlim_e = EXT_BITS'(xlim_ff);
   assign ylim_e = EXT_BITS'(ylim_ff);

   assign col_last = (px_e + EXT_BITS'(1)) == xlim_e;
   assign row_last = (py_e + EXT_BITS'(1)) == ylim_e;
   assign interior = (action_ff == ACT_OUTLINE)
                     && (py_e >= yt_ff) && ((py_e + {1'b0, t_ff}) < ye_ff)
                     && (px_e >= xt_ff) && ((px_e + {1'b0, t_ff}) < xe_ff);

   // row pitch is the effective window width
   assign scan_addr = ADDR_BITS'(py_ff) * ADDR_BITS'(eff_w[EWBITS-1:0])
                      + ADDR_BITS'(px_ff);
   assign pix_addr  = ADDR_BITS'(y_ff[YBITS-1:0]) * ADDR_BITS'(eff_w[EWBITS-1:0])
                      + ADDR_BITS'(x_ff[XBITS-1:0]);
   assign in_window = ({1'b0, x_ff} < eff_w) && ({1'b0, y_ff} < eff_h);

   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      if (cmd.load) begin
         px_in = req_pos_x[XBITS-1:0];
         py_in = req_pos_y[YBITS-1:0];
      end else if (cmd.scan_step) begin
         if (col_last) begin
            px_in = x_ff[XBITS-1:0];
            py_in = py_ff + YBITS'(1);
         end else begin
            px_in = px_ff + XBITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
   end

   assign s1_valid_in = cmd.scan_step && !interior;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         clr_cnt_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_BITS'(1);
         end
      end
   end

   // blend: products of the stored pixel and the paint, one pixel per cycle
   always_ff @(posedge clock) begin
      s1_addr_ff <= scan_addr;
      s2_addr_ff <= s1_addr_ff;
      for (int c = 0; c < 3; c++) begin
         pd_ff[c] <= ram_rdata[8*c +: 8] * paint_ff[31:24];
         ps_ff[c] <= paint_ff[8*c +: 8] * (8'hFF - paint_ff[31:24]);
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         blended[8*c +: 8] = div255(pd_ff[c]) + div255(ps_ff[c]);
      end
   end

   // single write port: clearing pass, pixel write or blend write-back
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = s2_addr_ff;
      ram_wdata = blended;
      if (cmd.clr_step) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else if (cmd.pix_wr) begin
         ram_we    = in_window;
         ram_waddr = pix_addr;
         ram_wdata = paint_ff[PIX_BITS-1:0];
      end else if (s2_valid_ff) begin
         ram_we    = 1'b1;
      end
   end

   assign ram_raddr = cmd.scan_step ? scan_addr : pix_addr;

   arfo_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff <= '0;
         pixel_ff <= '0;
      end else begin
         if (cmd.pix_wr && in_window) begin
            count_ff <= CNT_BITS'(1);
         end else if (s2_valid_ff) begin
            count_ff <= count_ff + CNT_BITS'(1);
         end
         if (cmd.pix_cap && in_window) begin
            pixel_ff <= ram_rdata;
         end
      end
   end

   assign status.clr_last   = (clr_cnt_ff == ADDR_BITS'(STORE_DEPTH - 1));
   assign status.action     = action_ff;
   assign status.rect_empty = !(({1'b0, x_ff} < xlim_e) && ({1'b0, y_ff} < ylim_e));
   assign status.scan_last  = col_last && row_last;
   assign status.pipe_busy  = s1_valid_ff || s2_valid_ff;

   assign rsp_pixel          = pixel_ff;
   assign rsp_pixels_written = count_ff;

endmodule

[rtl/core/alpha_rect_fill_outline_engine_unit.sv]
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+-------------------------------
// request  | start, busy, req_action .. req_paint    | taken when start && !busy
// response | rsp_valid, rsp_pixel, rsp_pixels_written| one-cycle strobe, no back-pressure
// config   | csr_write_en, csr_index, csr_wdata      | written when csr_write_en
//
// Steps: pixel write SETUP, DONE; pixel read SETUP, RDWAIT, DONE; empty rectangle
//   SETUP, DONE; other rectangles SETUP, SCAN of the clipped area (area <= 4096),
//   DRAIN, DONE; the drain is shorter when the last scanned pixels are outline interior.
//   The single write port of the frame store sets the rectangle rate: one blended
//   pixel per cycle; outline interior pixels are stepped over at the same rate, unwritten.
// Reset: a clearing pass zeroes the frame store, one entry a cycle;
//   busy stays high until it ends. Window registers reset to 64.
// The result is held for one cycle only; the receiver cannot stall it.
module alpha_rect_fill_outline_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [arfo_pkg::ACT_BITS-1:0]     req_action,
   input  logic [arfo_pkg::COORD_BITS-1:0]   req_pos_x,
   input  logic [arfo_pkg::COORD_BITS-1:0]   req_pos_y,
   input  logic [arfo_pkg::COORD_BITS-1:0]   req_rect_width,
   input  logic [arfo_pkg::COORD_BITS-1:0]   req_rect_height,
   input  logic [arfo_pkg::COORD_BITS-1:0]   req_border,
   input  logic [arfo_pkg::PAINT_BITS-1:0]   req_paint,
   output logic                              rsp_valid,
   output logic [arfo_pkg::PIX_BITS-1:0]     rsp_pixel,
   output logic [arfo_pkg::CNT_BITS-1:0]     rsp_pixels_written,
   input  logic                              csr_write_en,
   input  logic [arfo_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [arfo_pkg::CSR_BITS-1:0]     csr_wdata
);
   import arfo_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: clearing pass, item setup, scan and drain of the blend pipe
   arfo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   // window registers, scan counters, 3-stage read/blend/write pipe, frame store
   arfo_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_action         (req_action),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_rect_width     (req_rect_width),
      .req_rect_height    (req_rect_height),
      .req_border         (req_border),
      .req_paint          (req_paint),
      .rsp_pixel          (rsp_pixel),
      .rsp_pixels_written (rsp_pixels_written)
   );

`ifndef SYNTH
   // an accepted item keeps the block busy on the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   // result strobe lasts one cycle and ends the item
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe not a single cycle");

   // only reads return pixel data, and reads write nothing
   a_rsp_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pixels_written != '0) |-> (rsp_pixel == '0))
      else $error("pixel data on a writing item");

   // no item can write more than the whole store
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixels_written <= CNT_BITS'(STORE_DEPTH)))
      else $error("write count beyond store size");
`endif

endmodule

[bench/tb_alpha_rect_fill_outline_engine_unit.sv]
module tb_alpha_rect_fill_outline_engine_unit;
   import arfo_pkg::*;

   // Longest legal silence is the reset clearing pass or one full-window rectangle;
   // take that several times over.
   localparam int WATCHDOG_LIMIT = 20000;
   // Drain margin after the last result before a register write or the verdict.
   localparam int DRAIN_CYCLES   = 16;

   // One drawing item as presented on the req_ ports
   typedef struct packed {
      logic [ACT_BITS-1:0]   action;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0] rect_width;
      logic [COORD_BITS-1:0] rect_height;
      logic [COORD_BITS-1:0] border;
      logic [PAINT_BITS-1:0] paint;
   } draw_op_type;

   // What the engine reports for one item
   typedef struct packed {
      logic [PIX_BITS-1:0] pixel;
      logic [CNT_BITS-1:0] written;
   } draw_outcome_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [ACT_BITS-1:0]     req_action = ACT_WRITE;
   logic [COORD_BITS-1:0]   req_pos_x = '0;
   logic [COORD_BITS-1:0]   req_pos_y = '0;
   logic [COORD_BITS-1:0]   req_rect_width = '0;
   logic [COORD_BITS-1:0]   req_rect_height = '0;
   logic [COORD_BITS-1:0]   req_border = '0;
   logic [PAINT_BITS-1:0]   req_paint = '0;
   logic                    rsp_valid;
   logic [PIX_BITS-1:0]     rsp_pixel;
   logic [CNT_BITS-1:0]     rsp_pixels_written;
   logic                    csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_WINDOW_WIDTH;
   logic [CSR_BITS-1:0]     csr_wdata = '0;

   // Shadow of the engine: frame store plus window registers
   logic [PIX_BITS-1:0] shadow_frame [STORE_DEPTH];
   logic [CSR_BITS-1:0] win_w = WIN_RESET;
   logic [CSR_BITS-1:0] win_h = WIN_RESET;

   draw_outcome_type pending_outcomes [$];
   draw_outcome_type oldest;
   int               fail_count = 0;
   int               idle_cycles = 0;
   int               burst_left = 4;

   alpha_rect_fill_outline_engine_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_rect_width     (req_rect_width),
      .req_rect_height    (req_rect_height),
      .req_border         (req_border),
      .req_paint          (req_paint),
      .rsp_valid          (rsp_valid),
      .rsp_pixel          (rsp_pixel),
      .rsp_pixels_written (rsp_pixels_written),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Register value capped at the store dimension; 0 stays 0 (empty window).
   function automatic int unsigned eff_dim(input logic [CSR_BITS-1:0] v,
                                           input int unsigned cap);
      return (v > cap) ? cap : v;
   endfunction

   // Per channel: floor(dst*a/255) + floor(src*(255-a)/255); a = 255 keeps dst.
   function automatic logic [PIX_BITS-1:0] blend_pixel(input logic [PIX_BITS-1:0] dst,
                                                      input logic [PAINT_BITS-1:0] paint);
      int unsigned         a;
      int unsigned         d;
      int unsigned         s;
      logic [PIX_BITS-1:0] mixed;
      a = paint[31:24];
      for (int c = 0; c < 3; c++) begin
         d = dst[8*c +: 8];
         s = paint[8*c +: 8];
         mixed[8*c +: 8] = 8'((d * a) / 255 + (s * (255 - a)) / 255);
      end
      return mixed;
   endfunction

   // Applies one item to the shadow frame and returns what the engine should report.
   function automatic draw_outcome_type render_op(input draw_op_type op);
      int unsigned      ww;
      int unsigned      wh;
      int unsigned      xe;
      int unsigned      ye;
      int unsigned      xlim;
      int unsigned      ylim;
      int unsigned      addr;
      int unsigned      cnt;
      bit               interior;
      draw_outcome_type res;
      ww = eff_dim(win_w, MAX_WIDTH);
      wh = eff_dim(win_h, MAX_HEIGHT);
      res.pixel = '0;
      cnt = 0;
      if (op.action == ACT_WRITE || op.action == ACT_READ) begin
         if (op.pos_x < ww && op.pos_y < wh) begin
            addr = op.pos_y * ww + op.pos_x;
            if (addr < STORE_DEPTH) begin
               if (op.action == ACT_WRITE) begin
                  shadow_frame[addr] = op.paint[PIX_BITS-1:0];
                  cnt = 1;
               end else begin
                  res.pixel = shadow_frame[addr];
               end
            end
         end
      end else begin
         // extents in 32 bits: no wrap on x + w
         xe = op.pos_x + op.rect_width;
         ye = op.pos_y + op.rect_height;
         xlim = (xe < ww) ? xe : ww;
         ylim = (ye < wh) ? ye : wh;
         for (int unsigned py = op.pos_y; py < ylim; py++) begin
            for (int unsigned px = op.pos_x; px < xlim; px++) begin
               // interior is measured against the unclipped rectangle
               interior = (op.action == ACT_OUTLINE) &&
                          py >= op.pos_y + op.border && py + op.border < ye &&
                          px >= op.pos_x + op.border && px + op.border < xe;
               addr = py * ww + px;
               if (!interior && addr < STORE_DEPTH) begin
                  shadow_frame[addr] = blend_pixel(shadow_frame[addr], op.paint);
                  cnt++;
               end
            end
         end
      end
      res.written = CNT_BITS'(cnt);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic draw_op_type make_op(input logic [ACT_BITS-1:0] action,
                                           input int unsigned x, input int unsigned y,
                                           input int unsigned w, input int unsigned h,
                                           input int unsigned b,
                                           input logic [PAINT_BITS-1:0] paint);
      draw_op_type op;
      op.action      = action;
      op.pos_x       = COORD_BITS'(x);
      op.pos_y       = COORD_BITS'(y);
      op.rect_width  = COORD_BITS'(w);
      op.rect_height = COORD_BITS'(h);
      op.border      = COORD_BITS'(b);
      op.paint       = paint;
      return op;
   endfunction

   // Mostly small rectangles, some window-sized, a few over the full 12 bits.
   function automatic logic [COORD_BITS-1:0] random_extent();
      int unsigned r;
      r = $urandom_range(19, 0);
      if (r < 14)
         return COORD_BITS'($urandom_range(12, 0));
      else if (r < 18)
         return COORD_BITS'($urandom_range(64, 0));
      else
         return COORD_BITS'($urandom);
   endfunction

   function automatic draw_op_type random_item();
      draw_op_type op;
      int unsigned span_x;
      int unsigned span_y;
      span_x = eff_dim(win_w, MAX_WIDTH);
      span_y = eff_dim(win_h, MAX_HEIGHT);
      if (span_x == 0) span_x = 1;
      if (span_y == 0) span_y = 1;
      op.action = ACT_BITS'($urandom_range(3, 0));
      // positions mostly in or just past the window, sometimes anywhere
      op.pos_x = ($urandom_range(4, 0) == 0) ? COORD_BITS'($urandom)
                                              : COORD_BITS'($urandom_range(span_x, 0));
      op.pos_y = ($urandom_range(4, 0) == 0) ? COORD_BITS'($urandom)
                                              : COORD_BITS'($urandom_range(span_y, 0));
      op.rect_width  = random_extent();
      op.rect_height = random_extent();
      op.border = ($urandom_range(7, 0) == 0) ? COORD_BITS'($urandom)
                                               : COORD_BITS'($urandom_range(4, 0));
      op.paint = $urandom;
      // bias alpha toward opaque and fully transparent
      case ($urandom_range(3, 0))
         0: begin
            op.paint[31:24] = 8'h00;
         end
         1: begin
            op.paint[31:24] = 8'hFF;
         end
         default: ;
      endcase
      return op;
   endfunction

   // Present one item, wait for the engine to take it, record the expected
   // outcome. Start stays high across back-to-back items inside a burst.
   task automatic send_item(input draw_op_type op);
      req_action      <= op.action;
      req_pos_x       <= op.pos_x;
      req_pos_y       <= op.pos_y;
      req_rect_width  <= op.rect_width;
      req_rect_height <= op.rect_height;
      req_border      <= op.border;
      req_paint       <= op.paint;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      pending_outcomes.push_back(render_op(op));
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
         // now and then a long burst with no gaps at all
         burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(30, 10)
                                                   : $urandom_range(6, 1);
      end
   endtask

   // Drop start and wait until every outcome is in and the engine is idle.
   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // Both window registers, back to back; only called while idle.
   task automatic write_window(input logic [CSR_BITS-1:0] w, input logic [CSR_BITS-1:0] h);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_WINDOW_WIDTH;
      csr_wdata    <= w;
      @(posedge clock);
      win_w = w;
      csr_index    <= CSR_WINDOW_HEIGHT;
      csr_wdata    <= h;
      @(posedge clock);
      win_h = h;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Pixel write/read at the window corners, outside it, and at max coordinates.
   task automatic test_pixel_access();
      send_item(make_op(ACT_WRITE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
      send_item(make_op(ACT_READ, 0, 0, 0, 0, 0, 32'h0));
      send_item(make_op(ACT_WRITE, 63, 63, 4095, 4095, 4095, 32'h00A5_C3E1));
      send_item(make_op(ACT_READ, 63, 63, 0, 0, 0, 32'hFFFF_FFFF));
      send_item(make_op(ACT_WRITE, 64, 0, 0, 0, 0, 32'h0012_3456));
      send_item(make_op(ACT_READ, 0, 64, 0, 0, 0, 32'h0));
      send_item(make_op(ACT_WRITE, 4095, 4095, 0, 0, 0, 32'hFFFF_FFFF));
      send_item(make_op(ACT_READ, 4095, 4095, 0, 0, 0, 32'h0));
      // never-written pixel reads back the cleared value
      send_item(make_op(ACT_READ, 5, 5, 0, 0, 0, 32'h0));
   endtask

   // Fills: whole window opaque, transparent, half blend, empty and clipped.
   task automatic test_fill_cases();
      send_item(make_op(ACT_FILL, 0, 0, 64, 64, 0, 32'h0012_3456));
      send_item(make_op(ACT_FILL, 2, 2, 4, 4, 0, 32'hFF00_FF00));
      send_item(make_op(ACT_FILL, 1, 1, 3, 2, 0, 32'h80FE_DCBA));
      send_item(make_op(ACT_READ, 2, 2, 0, 0, 0, 32'h0));
      send_item(make_op(ACT_FILL, 3, 3, 0, 9, 0, 32'h0));
      send_item(make_op(ACT_FILL, 3, 3, 9, 0, 0, 32'h0));
      send_item(make_op(ACT_FILL, 64, 10, 5, 5, 0, 32'h0));
      // extent far past the window: clipped at the right and bottom edges
      send_item(make_op(ACT_FILL, 60, 60, 4095, 4095, 0, 32'h40FF_FFFF));
   endtask

   // Outlines: zero border, thin, oversized, half-size, and clipped at the edge.
   task automatic test_outline_cases();
      send_item(make_op(ACT_OUTLINE, 4, 4, 10, 10, 0, 32'h0));
      send_item(make_op(ACT_OUTLINE, 2, 3, 10, 8, 1, 32'h00C0_FFEE));
      send_item(make_op(ACT_OUTLINE, 20, 20, 5, 7, 4095, 32'h7F11_2233));
      send_item(make_op(ACT_OUTLINE, 30, 30, 6, 6, 3, 32'h0055_AA55));
      send_item(make_op(ACT_OUTLINE, 60, 10, 10, 6, 2, 32'h00AB_CDEF));
      // interior pixel must keep the earlier fill
      send_item(make_op(ACT_READ, 5, 5, 0, 0, 0, 32'h0));
   endtask

   // Window registers at zero (empty window) and above the store size (capped).
   task automatic test_window_extremes();
      quiesce();
      write_window(7'd0, 7'd0);
      send_item(make_op(ACT_FILL, 0, 0, 4, 4, 0, 32'h0));
      send_item(make_op(ACT_READ, 0, 0, 0, 0, 0, 32'h0));
      quiesce();
      write_window(7'd127, 7'd127);
      send_item(make_op(ACT_OUTLINE, 58, 58, 12, 12, 2, 32'h20FF_0000));
   endtask

   task automatic random_phase(input logic [CSR_BITS-1:0] w, input logic [CSR_BITS-1:0] h,
                               input int n);
      quiesce();
      write_window(w, h);
      repeat (n) send_item(random_item());
   endtask

   // Random traffic under several window settings; pitch changes between phases.
   task automatic test_random_traffic();
      random_phase(7'd64, 7'd64, 24);
      random_phase(7'd1, 7'd1, 14);
      random_phase(7'd17, 7'd9, 20);
      random_phase(7'd127, 7'd100, 20);
      random_phase(7'd0, 7'd40, 6);
      random_phase(7'd33, 7'd64, 30);
   endtask

   // ---------------------------------------------------------------------
   // Result checker: the engine strobes each outcome once, in item order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result: pixel %h pixels_written %0d",
                   rsp_pixel, rsp_pixels_written);
            fail_count++;
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_pixel !== oldest.pixel) begin
               $error("pixel: expected %h, got %h", oldest.pixel, rsp_pixel);
               fail_count++;
            end
            if (rsp_pixels_written !== oldest.written) begin
               $error("pixels_written: expected %0d, got %0d",
                      oldest.written, rsp_pixels_written);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: cycles where neither an item nor a result moves
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // waits out the clearing pass before the first item
      quiesce();
      test_pixel_access();
      test_fill_cases();
      test_outline_cases();
      test_window_extremes();
      test_random_traffic();
      quiesce();
      if (pending_outcomes.size() != 0) begin
         $error("%0d results never arrived", pending_outcomes.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
